### design/assert_macros.svh
// Shared assertion helpers; empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked implication, off while reset is applied.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### design/amsf_pkg.sv
`timescale 1ns / 1ps
package amsf_pkg;

    localparam int DIST_W = 25;
    localparam int POS_W  = 25;
    localparam int TGT_W  = 24;
    localparam int SPR_W  = 16;
    localparam int UPR_W  = 20;
    localparam int PROD_W = DIST_W + SPR_W;
    localparam int CNT_W  = 6;
    localparam int MUL_STEPS = UPR_W;
    localparam int DIV_STEPS = PROD_W;

    localparam logic [1:0] CMD_MOVE    = 2'd0;
    localparam logic [1:0] CMD_ENABLE  = 2'd1;
    localparam logic [1:0] CMD_DISABLE = 2'd2;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] REG_SPR   = 2'd0;
    localparam logic [1:0] REG_X_UPR = 2'd1;
    localparam logic [1:0] REG_Y_UPR = 2'd2;
    localparam logic [1:0] REG_Z_UPR = 2'd3;

    localparam logic [SPR_W-1:0] SPR_RESET   = 16'd1600;
    localparam logic [UPR_W-1:0] X_UPR_RESET = 20'd20000;
    localparam logic [UPR_W-1:0] Y_UPR_RESET = 20'd6000;
    localparam logic [UPR_W-1:0] Z_UPR_RESET = 20'd10000;

    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_RBR = 8'h5D;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_1   = 8'h31;
    localparam logic [7:0] CH_2   = 8'h32;
    localparam logic [7:0] CH_7   = 8'h37;
    localparam logic [7:0] CH_8   = 8'h38;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_B   = 8'h42;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [3:0] NIB_MASK = 4'hF;

    localparam logic [3:0] FRAME_LAST = 4'd9;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
        logic [PROD_W-1:0] a;
        logic [UPR_W-1:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] result;
    } t_alu_rsp;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [TGT_W-1:0] target_x;
        logic signed [TGT_W-1:0] target_y;
        logic signed [TGT_W-1:0] target_z;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       last;
        logic       step_overflow;
    } t_out_item;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [3:0] n;
        n = nib & NIB_MASK;
        if (n < 4'd10) begin
            hex_char = CH_0 + {4'h0, n};
        end else begin
            hex_char = CH_A + {4'h0, n} - 8'd10;
        end
    endfunction

endpackage

### design/amsf_alu.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Shared shift-add multiplier / restoring divider, one bit per cycle.
module amsf_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  amsf_pkg::t_alu_req i_req,
    output amsf_pkg::t_alu_rsp o_rsp
);
    import amsf_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    t_alu_op           r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0] r_a, n_a;
    logic [UPR_W-1:0]  r_b, n_b;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [UPR_W:0]    r_rem, n_rem;
    logic [UPR_W:0]    rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        rem_sh = {r_rem[UPR_W-1:0], r_a[PROD_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = (i_req.op == OP_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_acc  = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    // product fits PROD_W, so bits shifted out are zero
                    if (r_b[0]) begin
                        n_acc = r_acc + r_a;
                    end
                    n_a = r_a << 1;
                    n_b = r_b >> 1;
                end
                OP_DIV: begin
                    if (rem_sh >= {1'b0, r_b}) begin
                        n_rem = rem_sh - {1'b0, r_b};
                        n_acc = {r_acc[PROD_W-2:0], 1'b1};
                    end else begin
                        n_rem = rem_sh;
                        n_acc = {r_acc[PROD_W-2:0], 1'b0};
                    end
                    n_a = r_a << 1;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

    `ASSERT_NEVER(a_start_while_busy, i_clk, i_rst_n, i_req.start && r_busy)
    `ASSERT_NEVER(a_done_and_busy, i_clk, i_rst_n, r_done && r_busy)
    `ASSERT_CLK(a_start_runs, i_clk, i_rst_n, i_req.start |=> r_busy)

endmodule

### design/absolute_move_step_frame_encoder_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Channel | Dir | Handshake             | Payload
// in      | in  | i_in_valid/o_in_stall  | t_in_item  (cmd, targets)
// out     | out | o_out_valid/i_out_stall| t_out_item (byte, flags)
// cfg     | in  | i_cfg_we               | i_cfg_idx, i_cfg_data
// Move: per axis a setup, then mul, div, mul, div on the shared mul/div unit
// (20, 41, 20, 41 bit steps), then 10 byte loads, 30 bytes per move.
// Enable/disable: 10 byte transfers. cmd 3 is taken and dropped.
// The input stalls while a command is in work; one output register holds the
// current byte, and a stalled output simply holds the sequencer in emit.
// Reset is synchronous; positions clear and config returns to defaults.
module absolute_move_step_frame_encoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  amsf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output amsf_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [19:0]         i_cfg_data
);
    import amsf_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_MUL1 = 7'b0000100,
        ST_DIV1 = 7'b0001000,
        ST_MUL2 = 7'b0010000,
        ST_DIV2 = 7'b0100000,
        ST_EMIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [SPR_W-1:0] r_spr;
    logic [UPR_W-1:0] r_xupr, r_yupr, r_zupr;

    logic signed [POS_W-1:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y, r_pos_z, n_pos_z;
    logic signed [TGT_W-1:0] r_tx, r_ty, r_tz;
    logic             r_zfirst;
    logic             r_fixed, n_fixed;
    logic [1:0]       r_ax, n_ax;
    logic [1:0]       r_cur, n_cur;
    logic             r_up, n_up;
    logic [UPR_W-1:0] r_upr, n_upr;
    logic [7:0]       r_dirch, n_dirch;
    logic [15:0]      r_steps, n_steps;
    logic             r_ovf, n_ovf;
    logic [3:0]       r_bi, n_bi;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic in_xfer, load;
    logic [1:0] ax_sel;
    logic signed [POS_W-1:0] pos_sel;
    logic signed [POS_W-1:0] tgt_sel;
    logic signed [POS_W:0]   diff;
    logic [UPR_W-1:0] upr_sel, spr_eff;
    logic [DIST_W-1:0] moved;
    logic [7:0] byte_val;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign spr_eff  = (r_spr == '0) ? UPR_W'(1) : {{(UPR_W-SPR_W){1'b0}}, r_spr};
    assign load     = !r_out_valid || !i_out_stall;
    assign moved    = alu_rsp.result[DIST_W-1:0];

    always_comb begin
        case (r_ax)
            2'd0:    ax_sel = r_zfirst ? AX_Z : AX_X;
            2'd1:    ax_sel = r_zfirst ? AX_X : AX_Y;
            default: ax_sel = r_zfirst ? AX_Y : AX_Z;
        endcase
        case (ax_sel)
            AX_X: begin
                pos_sel = r_pos_x;
                tgt_sel = POS_W'(r_tx);
                upr_sel = r_xupr;
            end
            AX_Y: begin
                pos_sel = r_pos_y;
                tgt_sel = POS_W'(r_ty);
                upr_sel = r_yupr;
            end
            default: begin
                pos_sel = r_pos_z;
                tgt_sel = POS_W'(r_tz);
                upr_sel = r_zupr;
            end
        endcase
        diff = {tgt_sel[POS_W-1], tgt_sel} - {pos_sel[POS_W-1], pos_sel};
    end

    always_comb begin
        case (r_bi)
            4'd0:    byte_val = CH_LBR;
            4'd2:    byte_val = r_dirch;
            4'd3:    byte_val = hex_char(r_steps[7:4]);
            4'd4:    byte_val = hex_char(r_steps[3:0]);
            4'd5:    byte_val = hex_char(r_steps[15:12]);
            4'd6:    byte_val = hex_char(r_steps[11:8]);
            4'd9:    byte_val = CH_RBR;
            default: byte_val = CH_0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_pos_z     = r_pos_z;
        n_fixed     = r_fixed;
        n_ax        = r_ax;
        n_cur       = r_cur;
        n_up        = r_up;
        n_upr       = r_upr;
        n_dirch     = r_dirch;
        n_steps     = r_steps;
        n_ovf       = r_ovf;
        n_bi        = r_bi;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        alu_req     = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_ax  = 2'd0;
                    n_bi  = 4'd0;
                    n_ovf = 1'b0;
                    case (i_in_data.cmd)
                        CMD_MOVE: begin
                            n_fixed = 1'b0;
                            n_state = ST_PREP;
                        end
                        CMD_ENABLE, CMD_DISABLE: begin
                            n_fixed = 1'b1;
                            n_steps = '0;
                            n_dirch = (i_in_data.cmd == CMD_ENABLE) ? CH_2 : CH_1;
                            n_pos_x = '0;
                            n_pos_y = '0;
                            n_pos_z = '0;
                            n_state = ST_EMIT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PREP: begin
                n_cur   = ax_sel;
                n_up    = !diff[POS_W] && (diff != '0);
                n_upr   = (upr_sel == '0) ? UPR_W'(1) : upr_sel;
                case (ax_sel)
                    AX_X:    n_dirch = n_up ? CH_7 : CH_8;
                    AX_Y:    n_dirch = n_up ? CH_A : CH_9;
                    default: n_dirch = n_up ? CH_C : CH_B;
                endcase
                alu_req.start = 1'b1;
                alu_req.op    = OP_MUL;
                alu_req.a     = PROD_W'(diff[POS_W] ? DIST_W'(-diff) : DIST_W'(diff));
                alu_req.b     = spr_eff;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                if (alu_rsp.done) begin
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_DIV;
                    alu_req.a     = alu_rsp.result;
                    alu_req.b     = r_upr;
                    n_state = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (alu_rsp.done) begin
                    n_steps = alu_rsp.result[15:0];
                    n_ovf   = |alu_rsp.result[PROD_W-1:16];
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_MUL;
                    alu_req.a     = alu_rsp.result;
                    alu_req.b     = r_upr;
                    n_state = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (alu_rsp.done) begin
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_DIV;
                    alu_req.a     = alu_rsp.result;
                    alu_req.b     = spr_eff;
                    n_state = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (alu_rsp.done) begin
                    case (r_cur)
                        AX_X:    n_pos_x = r_up ? r_pos_x + moved : r_pos_x - moved;
                        AX_Y:    n_pos_y = r_up ? r_pos_y + moved : r_pos_y - moved;
                        default: n_pos_z = r_up ? r_pos_z + moved : r_pos_z - moved;
                    endcase
                    n_bi    = 4'd0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load) begin
                    n_out_valid         = 1'b1;
                    n_out.tx_byte       = byte_val;
                    n_out.frame_end     = (r_bi == FRAME_LAST);
                    n_out.last          = (r_bi == FRAME_LAST) && (r_fixed || r_ax == 2'd2);
                    n_out.step_overflow = r_ovf;
                    n_bi = r_bi + 4'd1;
                    if (r_bi == FRAME_LAST) begin
                        n_bi = 4'd0;
                        if (r_fixed || r_ax == 2'd2) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_ax    = r_ax + 2'd1;
                            n_state = ST_PREP;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bi        <= 4'd0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_spr       <= SPR_RESET;
            r_xupr      <= X_UPR_RESET;
            r_yupr      <= Y_UPR_RESET;
            r_zupr      <= Z_UPR_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bi        <= n_bi;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_pos_z     <= n_pos_z;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SPR:   r_spr  <= i_cfg_data[SPR_W-1:0];
                    REG_X_UPR: r_xupr <= i_cfg_data;
                    REG_Y_UPR: r_yupr <= i_cfg_data;
                    REG_Z_UPR: r_zupr <= i_cfg_data;
                    default:   r_spr  <= r_spr;
                endcase
            end
        end
        if (in_xfer) begin
            r_tx     <= i_in_data.target_x;
            r_ty     <= i_in_data.target_y;
            r_tz     <= i_in_data.target_z;
            r_zfirst <= (i_in_data.target_z > 0);
        end
        r_fixed <= n_fixed;
        r_ax    <= n_ax;
        r_cur   <= n_cur;
        r_up    <= n_up;
        r_upr   <= n_upr;
        r_dirch <= n_dirch;
        r_steps <= n_steps;
        r_ovf   <= n_ovf;
        r_out   <= n_out;
    end

    amsf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_NEVER(a_idle_alu_busy, i_clk, i_rst_n, (r_state == ST_IDLE) && alu_rsp.busy)
    `ASSERT_CLK(a_move_starts, i_clk, i_rst_n,
        (in_xfer && i_in_data.cmd == CMD_MOVE) |=> (r_state == ST_PREP))
    `ASSERT_NEVER(a_byte_index, i_clk, i_rst_n, r_bi > FRAME_LAST)

endmodule

### verif/absolute_move_step_frame_encoder_core_test.sv
`timescale 1ns / 1ps
module absolute_move_step_frame_encoder_core_test;
    import amsf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [19:0] i_cfg_data;

    absolute_move_step_frame_encoder_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // predictor state
    logic [15:0] spr_q;
    logic [19:0] upr_q [3];
    logic signed [24:0] axis_pos [3];

    t_in_item  cmd_queue [$];
    t_out_item byte_queue [$];
    int errors;
    bit hold_off;
    bit pause_sender;
    bit cfg_busy;

    task automatic report(input string what, input t_out_item got, input t_out_item exp);
        $display("mismatch %s: got %h/%b%b%b expected %h/%b%b%b", what,
                 got.tx_byte, got.frame_end, got.last, got.step_overflow,
                 exp.tx_byte, exp.frame_end, exp.last, exp.step_overflow);
        errors++;
    endtask

    function automatic logic [7:0] nib_char(input logic [3:0] n);
        return (n < 4'd10) ? (CH_0 + 8'(n)) : (CH_A + 8'(n) - 8'd10);
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit fe, input bit ovf);
        t_out_item o;
        o.tx_byte = b;
        o.frame_end = fe;
        o.last = 1'b0;
        o.step_overflow = ovf;
        byte_queue.push_back(o);
    endtask

    task automatic predict_axis(input int ax, input logic signed [23:0] tgt,
                                input logic [7:0] pos_ch, input logic [7:0] neg_ch);
        longint spr, upr, p, t, span, steps, moved;
        bit up, ovf;
        logic [15:0] s16;
        spr = (spr_q == 0) ? 1 : longint'(spr_q);
        upr = (upr_q[ax] == 0) ? 1 : longint'(upr_q[ax]);
        p = longint'(axis_pos[ax]);
        t = longint'(tgt);
        up = t > p;
        span = up ? t - p : p - t;
        steps = span * spr / upr;
        moved = steps * upr / spr;
        ovf = steps > 65535;
        s16 = steps[15:0];
        push_byte(CH_LBR, 0, ovf);
        push_byte(CH_0, 0, ovf);
        push_byte(up ? pos_ch : neg_ch, 0, ovf);
        push_byte(nib_char(s16[7:4]), 0, ovf);
        push_byte(nib_char(s16[3:0]), 0, ovf);
        push_byte(nib_char(s16[15:12]), 0, ovf);
        push_byte(nib_char(s16[11:8]), 0, ovf);
        push_byte(CH_0, 0, ovf);
        push_byte(CH_0, 0, ovf);
        push_byte(CH_RBR, 1, ovf);
        axis_pos[ax] = up ? axis_pos[ax] + 25'(moved) : axis_pos[ax] - 25'(moved);
    endtask

    task automatic predict_command(input t_in_item it);
        if (it.cmd == CMD_MOVE) begin
            if (it.target_z > 0) begin
                predict_axis(AX_Z, it.target_z, CH_C, CH_B);
                predict_axis(AX_X, it.target_x, CH_7, CH_8);
                predict_axis(AX_Y, it.target_y, CH_A, CH_9);
            end else begin
                predict_axis(AX_X, it.target_x, CH_7, CH_8);
                predict_axis(AX_Y, it.target_y, CH_A, CH_9);
                predict_axis(AX_Z, it.target_z, CH_C, CH_B);
            end
        end else if (it.cmd == CMD_ENABLE || it.cmd == CMD_DISABLE) begin
            push_byte(CH_LBR, 0, 0);
            push_byte(CH_0, 0, 0);
            push_byte(it.cmd == CMD_ENABLE ? CH_2 : CH_1, 0, 0);
            for (int i = 0; i < 6; i++) push_byte(CH_0, 0, 0);
            push_byte(CH_RBR, 1, 0);
            for (int a = 0; a < 3; a++) axis_pos[a] = '0;
        end else begin
            return;
        end
        byte_queue[$].last = 1'b1;
    endtask

    // driver: bursts and gaps; the offered item stays at the queue front
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (i_in_valid && o_in_stall) begin
            // hold payload
        end else begin
            if (i_in_valid) begin
                predict_command(i_in_data);
                void'(cmd_queue.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (cmd_queue.size() > 0 && !pause_sender && !cfg_busy) begin
                i_in_valid <= 1'b1;
                i_in_data <= cmd_queue[0];
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 6);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int stall_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_mode <= 0;
        end else if (hold_off) begin
            i_out_stall <= 1'b1;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (byte_queue.size() == 0) begin
                report("unexpected transfer", o_out_data, '0);
            end else begin
                t_out_item e;
                e = byte_queue.pop_front();
                if (o_out_data.tx_byte !== e.tx_byte) report("tx_byte", o_out_data, e);
                if (o_out_data.frame_end !== e.frame_end) report("frame_end", o_out_data, e);
                if (o_out_data.last !== e.last) report("last", o_out_data, e);
                if (o_out_data.step_overflow !== e.step_overflow)
                    report("step_overflow", o_out_data, e);
            end
        end
    end

    function automatic t_in_item make_cmd(input logic [1:0] c, input int x, input int y,
                                          input int z);
        t_in_item it;
        it.cmd = c;
        it.target_x = 24'(x);
        it.target_y = 24'(y);
        it.target_z = 24'(z);
        return it;
    endfunction

    function automatic int rand_target();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 2000) - 1000;
            1: return $urandom_range(0, 200000) - 100000;
            2: return (($urandom_range(0, 1)) ? 8388607 : -8388608);
            default: return int'($urandom & 32'hFFFFFF) - 8388608;
        endcase
    endfunction

    task automatic drain();
        while (cmd_queue.size() != 0 || i_in_valid || byte_queue.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SPR) spr_q = val[15:0];
        else upr_q[idx - 1] = val;
    endtask

    task automatic random_cmds(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0) cmd_queue.push_back(make_cmd(CMD_ENABLE, rand_target(),
                                                     rand_target(), rand_target()));
            else if (r == 1) cmd_queue.push_back(make_cmd(CMD_DISABLE, rand_target(),
                                                          rand_target(), rand_target()));
            else if (r == 2) cmd_queue.push_back(make_cmd(2'd3, rand_target(),
                                                          rand_target(), rand_target()));
            else cmd_queue.push_back(make_cmd(CMD_MOVE, rand_target(), rand_target(),
                                              rand_target()));
        end
    endtask

    initial begin
        errors = 0;
        hold_off = 0;
        pause_sender = 0;
        cfg_busy = 1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        spr_q = SPR_RESET;
        upr_q[0] = X_UPR_RESET;
        upr_q[1] = Y_UPR_RESET;
        upr_q[2] = Z_UPR_RESET;
        for (int a = 0; a < 3; a++) axis_pos[a] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config
        cmd_queue.push_back(make_cmd(CMD_ENABLE, 5, 5, 5));
        cmd_queue.push_back(make_cmd(CMD_MOVE, 1000, -500, 300));
        cmd_queue.push_back(make_cmd(CMD_MOVE, 1000, -500, 300));
        cmd_queue.push_back(make_cmd(CMD_MOVE, -20000, 6000, -1));
        cmd_queue.push_back(make_cmd(CMD_MOVE, 8388607, -8388608, 8388607));
        cmd_queue.push_back(make_cmd(2'd3, 1, 2, 3));
        cmd_queue.push_back(make_cmd(CMD_MOVE, -8388608, 8388607, -8388608));
        cmd_queue.push_back(make_cmd(CMD_DISABLE, -1, -1, -1));
        cmd_queue.push_back(make_cmd(CMD_MOVE, 0, 0, 0));
        cfg_busy = 0;
        drain();

        // extremes: zero and max registers
        cfg_busy = 1;
        write_reg(REG_SPR, 20'd65535);
        write_reg(REG_X_UPR, 20'd1);
        write_reg(REG_Y_UPR, 20'd0);
        write_reg(REG_Z_UPR, 20'hFFFFF);
        cmd_queue.push_back(make_cmd(CMD_MOVE, 8388607, -8388608, 1));
        cmd_queue.push_back(make_cmd(CMD_MOVE, -3, 77, -8388608));
        cmd_queue.push_back(make_cmd(CMD_MOVE, 1, 1, 8388607));
        cfg_busy = 0;
        drain();
        cfg_busy = 1;
        write_reg(REG_SPR, 20'd0);
        write_reg(REG_X_UPR, 20'hFFFFF);
        write_reg(REG_Y_UPR, 20'd1);
        write_reg(REG_Z_UPR, 20'd0);
        cmd_queue.push_back(make_cmd(CMD_MOVE, 4000000, -4000000, -70000));
        cmd_queue.push_back(make_cmd(CMD_ENABLE, 0, 0, 0));
        cmd_queue.push_back(make_cmd(CMD_MOVE, -8388608, 8388607, 65536));
        cfg_busy = 0;
        drain();

        // random phases with random configs
        for (int ph = 0; ph < 4; ph++) begin
            cfg_busy = 1;
            write_reg(REG_SPR, 20'($urandom_range(0, 65535)));
            write_reg(REG_X_UPR, 20'($urandom_range(0, 1048575)));
            write_reg(REG_Y_UPR, 20'($urandom_range(1, 30000)));
            write_reg(REG_Z_UPR, 20'($urandom_range(1, 1048575)));
            random_cmds(60);
            cfg_busy = 0;
            if (ph == 1) begin
                // long hold-off while the sender keeps offering
                hold_off = 1;
                repeat (1500) @(posedge i_clk);
                hold_off = 0;
            end
            if (ph == 2) begin
                while (cmd_queue.size() > 25) @(posedge i_clk);
                pause_sender = 1;
                while (byte_queue.size() != 0 || i_in_valid) @(posedge i_clk);
                pause_sender = 0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
